### src/pli_pkg.sv
// Shared types and constants of the piecewise linear interpolator.
package pli_pkg;

	localparam int IDX_W          = 6;
	localparam int PCOUNT_W       = 7;
	localparam int MAX_POINTS_DEF = 64;
	localparam int X_WIDTH_DEF    = 16;
	localparam int Y_WIDTH_DEF    = 24;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MAG,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} pli_state_t;

	// Control part of the item travelling down the breakpoint chain.
	typedef struct packed {
		logic valid;
		logic done;
	} pli_ctl_t;

endpackage

### src/pli_cell.sv
// One breakpoint cell of the chain: holds an entry and tests the passing query.
module pli_cell #(
	parameter int IDX     = 0,
	parameter int X_WIDTH = pli_pkg::X_WIDTH_DEF,
	parameter int Y_WIDTH = pli_pkg::Y_WIDTH_DEF,
	parameter int CNT_W   = pli_pkg::PCOUNT_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [pli_pkg::IDX_W-1:0]   wr_idx,
	input  logic [X_WIDTH-1:0]          wr_x,
	input  logic signed [Y_WIDTH-1:0]   wr_y,
	input  logic [CNT_W-1:0]            count,
	input  pli_pkg::pli_ctl_t           in_ctl,
	input  logic [X_WIDTH-1:0]          in_q,
	input  logic [X_WIDTH-1:0]          in_xa,
	input  logic [X_WIDTH-1:0]          in_xb,
	input  logic signed [Y_WIDTH-1:0]   in_ya,
	input  logic signed [Y_WIDTH-1:0]   in_yb,
	output pli_pkg::pli_ctl_t           out_ctl,
	output logic [X_WIDTH-1:0]          out_q,
	output logic [X_WIDTH-1:0]          out_xa,
	output logic [X_WIDTH-1:0]          out_xb,
	output logic signed [Y_WIDTH-1:0]   out_ya,
	output logic signed [Y_WIDTH-1:0]   out_yb
);
	import pli_pkg::*;

	logic [X_WIDTH-1:0]        x_q;
	logic signed [Y_WIDTH-1:0] y_q;
	pli_ctl_t                  ctl_q;
	logic [X_WIDTH-1:0]        q_q;
	logic [X_WIDTH-1:0]        xa_q;
	logic [X_WIDTH-1:0]        xb_q;
	logic signed [Y_WIDTH-1:0] ya_q;
	logic signed [Y_WIDTH-1:0] yb_q;
	logic                      act;
	logic                      hit;
	logic                      pass_prev;

	assign act       = CNT_W'(IDX) < count;
	assign hit       = in_ctl.valid && !in_ctl.done && act && (in_q < x_q);
	assign pass_prev = in_ctl.valid && !in_ctl.done && act && !hit;

	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_idx) == IDX)) begin
			x_q <= wr_x;
			y_q <= wr_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid <= in_ctl.valid;
			ctl_q.done  <= in_ctl.done | hit;
		end
	end

	// First cell clamps below its abscissa: zero offset, both ordinates its own.
	always_ff @(posedge clk) begin
		q_q <= in_q;
		if (hit) begin
			xa_q <= (IDX == 0) ? in_q : in_xa;
			ya_q <= (IDX == 0) ? y_q : in_ya;
			xb_q <= x_q;
			yb_q <= y_q;
		end else if (pass_prev) begin
			xa_q <= x_q;
			ya_q <= y_q;
			xb_q <= in_xb;
			yb_q <= in_yb;
		end else begin
			xa_q <= in_xa;
			ya_q <= in_ya;
			xb_q <= in_xb;
			yb_q <= in_yb;
		end
	end

	assign out_ctl = ctl_q;
	assign out_q   = q_q;
	assign out_xa  = xa_q;
	assign out_xb  = xb_q;
	assign out_ya  = ya_q;
	assign out_yb  = yb_q;

endmodule

### src/pli_div.sv
// Restoring divider, one quotient bit per cycle.
module pli_div #(
	parameter int N_W = 41,
	parameter int D_W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [N_W-1:0] quo
);
	import pli_pkg::*;

	localparam int CW = (N_W > 1) ? $clog2(N_W) : 1;

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] den_q;
	logic [N_W-1:0] quo_q;
	logic [D_W:0]   shifted;
	logic [D_W:0]   diff;
	logic           ge;

	assign shifted = {rem_q, quo_q[N_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### src/piecewise_linear_interpolator.sv
// Piecewise linear interpolator: chain of breakpoint cells, then multiply and divide.
// A write item is taken in the idle state. A query scans the chain of MAX_POINTS cells,
// then passes slope set-up (ST_MAG, ST_MUL), the divider and ST_FIN, which loads the
// result once the output register is free; only then is the next item taken.
// Reset clears control and sets the point count to one; breakpoints hold no reset.
module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
	parameter int X_WIDTH    = pli_pkg::X_WIDTH_DEF,
	parameter int Y_WIDTH    = pli_pkg::Y_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// entry_index, entry_x, entry_y, query_x
	input  logic [((pli_pkg::IDX_W + 2*X_WIDTH + Y_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// operation
	input  logic                                   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// result_y
	output logic [((Y_WIDTH + 7) / 8) * 8 - 1:0]   m_axis_tdata,
	input  logic                                   cfg_we,
	input  logic [pli_pkg::PCOUNT_W-1:0]           cfg_wdata
);
	import pli_pkg::*;

	localparam int OUT_TD_W = ((Y_WIDTH + 7) / 8) * 8;
	localparam int CNT_W    = ($clog2(MAX_POINTS + 1) > PCOUNT_W) ?
	                          $clog2(MAX_POINTS + 1) : PCOUNT_W;
	localparam int EX_LO    = IDX_W;
	localparam int EY_LO    = EX_LO + X_WIDTH;
	localparam int QX_LO    = EY_LO + Y_WIDTH;
	localparam int P_W      = Y_WIDTH + 1 + X_WIDTH;

	pli_state_t                state_q, state_d;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          cfg_ext;
	logic                      in_rdy;
	logic                      div_start;
	logic                      div_done;
	logic                      out_load;
	logic                      out_valid_q;
	logic [P_W-1:0]            quo;
	logic [P_W-1:0]            prod;

	logic [IDX_W-1:0]          f_idx;
	logic [X_WIDTH-1:0]        f_ex;
	logic signed [Y_WIDTH-1:0] f_ey;
	logic [X_WIDTH-1:0]        f_qx;
	logic                      wr_en;

	pli_ctl_t                  ctl_w [MAX_POINTS+1];
	logic [X_WIDTH-1:0]        q_w   [MAX_POINTS+1];
	logic [X_WIDTH-1:0]        xa_w  [MAX_POINTS+1];
	logic [X_WIDTH-1:0]        xb_w  [MAX_POINTS+1];
	logic signed [Y_WIDTH-1:0] ya_w  [MAX_POINTS+1];
	logic signed [Y_WIDTH-1:0] yb_w  [MAX_POINTS+1];

	logic [X_WIDTH-1:0]        t_q;
	logic [X_WIDTH-1:0]        d_q;
	logic [Y_WIDTH:0]          dy_q;
	logic signed [Y_WIDTH-1:0] ya_q;
	logic                      clamp_q;
	logic                      neg_q;
	logic [Y_WIDTH:0]          mag_q;
	logic [Y_WIDTH:0]          ya_ext;
	logic [Y_WIDTH:0]          sum;
	logic [Y_WIDTH-1:0]        res_q;

	assign f_idx = s_axis_tdata[IDX_W-1:0];
	assign f_ex  = s_axis_tdata[EY_LO-1:EX_LO];
	assign f_ey  = s_axis_tdata[QX_LO-1:EY_LO];
	assign f_qx  = s_axis_tdata[QX_LO+X_WIDTH-1:QX_LO];

	// Configuration: saturate the point count into 1..MAX_POINTS.
	assign cfg_ext = CNT_W'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(1);
		end else if (cfg_we) begin
			priority if (cfg_ext == '0)
				cnt_q <= CNT_W'(1);
			else if (cfg_ext > CNT_W'(MAX_POINTS))
				cnt_q <= CNT_W'(MAX_POINTS);
			else
				cnt_q <= cfg_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_rdy    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (s_axis_tvalid && s_axis_tuser == OP_QUERY)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (ctl_w[MAX_POINTS].valid)
					state_d = ST_MAG;
			end
			ST_MAG: state_d = ST_MUL;
			ST_MUL: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_axis_tready = in_rdy;
	assign wr_en         = in_rdy && s_axis_tvalid && s_axis_tuser == OP_WRITE;

	// Inject the query at the head of the chain.
	assign ctl_w[0].valid = in_rdy && s_axis_tvalid && s_axis_tuser == OP_QUERY;
	assign ctl_w[0].done  = 1'b0;
	assign q_w[0]         = f_qx;
	assign xa_w[0]        = '0;
	assign xb_w[0]        = '0;
	assign ya_w[0]        = '0;
	assign yb_w[0]        = '0;

	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		pli_cell #(
			.IDX     (k),
			.X_WIDTH (X_WIDTH),
			.Y_WIDTH (Y_WIDTH),
			.CNT_W   (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_idx  (f_idx),
			.wr_x    (f_ex),
			.wr_y    (f_ey),
			.count   (cnt_q),
			.in_ctl  (ctl_w[k]),
			.in_q    (q_w[k]),
			.in_xa   (xa_w[k]),
			.in_xb   (xb_w[k]),
			.in_ya   (ya_w[k]),
			.in_yb   (yb_w[k]),
			.out_ctl (ctl_w[k+1]),
			.out_q   (q_w[k+1]),
			.out_xa  (xa_w[k+1]),
			.out_xb  (xb_w[k+1]),
			.out_ya  (ya_w[k+1]),
			.out_yb  (yb_w[k+1])
		);
	end

	// Latch the segment, then its slope; no segment found: clamp to the last ordinate in use.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && ctl_w[MAX_POINTS].valid) begin
			t_q     <= q_w[MAX_POINTS] - xa_w[MAX_POINTS];
			d_q     <= xb_w[MAX_POINTS] - xa_w[MAX_POINTS];
			dy_q    <= {yb_w[MAX_POINTS][Y_WIDTH-1], yb_w[MAX_POINTS]} -
			           {ya_w[MAX_POINTS][Y_WIDTH-1], ya_w[MAX_POINTS]};
			ya_q    <= ya_w[MAX_POINTS];
			clamp_q <= !ctl_w[MAX_POINTS].done;
		end
		if (state_q == ST_MAG) begin
			neg_q <= dy_q[Y_WIDTH];
			mag_q <= dy_q[Y_WIDTH] ? -dy_q : dy_q;
		end
		if (out_load)
			res_q <= clamp_q ? ya_q : sum[Y_WIDTH-1:0];
	end

	assign prod = P_W'(mag_q) * P_W'(t_q);

	pli_div #(
		.N_W (P_W),
		.D_W (X_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (d_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign ya_ext = {ya_q[Y_WIDTH-1], ya_q};
	assign sum    = neg_q ? ya_ext - quo[Y_WIDTH:0] : ya_ext + quo[Y_WIDTH:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TD_W'(res_q);

	a_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_w[MAX_POINTS].valid |-> state_q == ST_SCAN)
		else $error("query left the chain outside the scan state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid)
		else $error("result loaded but not presented");

endmodule

### sim/tb_piecewise_linear_interpolator.sv
// Testbench: breakpoint table loads and interpolation queries against a built-in predictor.
module tb_piecewise_linear_interpolator;
	import pli_pkg::*;

	localparam int NPTS        = MAX_POINTS_DEF;
	localparam int XW          = X_WIDTH_DEF;
	localparam int YW          = Y_WIDTH_DEF;
	localparam int TDATA_W     = ((IDX_W + 2*XW + YW + 7) / 8) * 8;
	localparam int RDATA_W     = ((YW + 7) / 8) * 8;
	localparam int DRAIN_CYCLES = 150;
	localparam int STALL_LIMIT = 5000;
	localparam int ITEM_TARGET = 1400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata = '0;
	logic                  s_axis_tuser = OP_WRITE;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [RDATA_W-1:0]    m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [PCOUNT_W-1:0]   cfg_wdata = '0;

	// predictor state
	logic [XW-1:0]         knot_x [NPTS];
	logic signed [YW-1:0]  knot_y [NPTS];
	logic [PCOUNT_W-1:0]   point_count_reg = 7'd1;
	logic [YW-1:0]         expected_y [$];
	logic [YW-1:0]         head_y;

	int errors = 0;
	int n_items = 0;
	int n_queries = 0;
	int n_writes = 0;
	int n_phases = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	logic [11:0] ready_phase = '0;

	piecewise_linear_interpolator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int points_in_use();
		if (point_count_reg == 0)
			return 1;
		if (point_count_reg > NPTS)
			return NPTS;
		return point_count_reg;
	endfunction

	function automatic logic [YW-1:0] interpolate(input logic [XW-1:0] qx);
		int n;
		longint ya, yb, dy, mag, t, d, q;
		logic [YW-1:0] r;
		n = points_in_use();
		if (qx < knot_x[0])
			return knot_y[0];
		for (int i = 0; i + 1 < n; i++) begin
			if (qx < knot_x[i+1]) begin
				ya  = longint'(knot_y[i]);
				yb  = longint'(knot_y[i+1]);
				dy  = yb - ya;
				mag = (dy < 0) ? -dy : dy;
				t   = longint'(qx) - longint'(knot_x[i]);
				d   = longint'(knot_x[i+1]) - longint'(knot_x[i]);
				// truncate toward zero: floor the magnitude, then apply the sign
				q   = (mag * t) / d;
				r   = (dy < 0) ? YW'(ya - q) : YW'(ya + q);
				return r;
			end
		end
		return knot_y[n-1];
	endfunction

	task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
			input logic [XW-1:0] ex, input logic signed [YW-1:0] ey,
			input logic [XW-1:0] qx);
		logic [TDATA_W-1:0] item;
		item = '0;
		item[IDX_W-1:0]                  = idx;
		item[IDX_W +: XW]                = ex;
		item[IDX_W+XW +: YW]             = ey;
		item[IDX_W+XW+YW +: XW]          = qx;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				if ($urandom_range(0, 1) != 0)
					repeat ($urandom_range(1, 8)) @(posedge clk);
				else
					repeat ($urandom_range(20, 140)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= item;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		n_items++;
		if (op == OP_WRITE) begin
			knot_x[idx] = ex;
			knot_y[idx] = ey;
			n_writes++;
		end else begin
			expected_y.push_back(interpolate(qx));
			n_queries++;
		end
	endtask

	task automatic write_point(input logic [IDX_W-1:0] idx, input logic [XW-1:0] ex,
			input logic signed [YW-1:0] ey);
		send_item(OP_WRITE, idx, ex, ey, XW'($urandom));
	endtask

	task automatic query(input logic [XW-1:0] qx);
		send_item(OP_QUERY, IDX_W'($urandom), XW'($urandom), YW'($urandom), qx);
	endtask

	// Hold the register write until the block has gone quiet.
	task automatic set_point_count(input logic [PCOUNT_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (expected_y.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		point_count_reg = value;
		burst_left = 0;
	endtask

	task automatic test_one_point();
		set_point_count(7'd0);
		write_point(6'd0, 16'd1000, 24'sh7FFFFF);
		query(16'd0);
		query(16'd999);
		query(16'd1000);
		query(16'hFFFF);
	endtask

	task automatic test_segments();
		// steepest fall, then a zero-width step, then a shallow slope to the top
		write_point(6'd1, 16'd3000, -24'sd8388608);
		write_point(6'd2, 16'd3000, 24'sd0);
		write_point(6'd3, 16'hFFFF, -24'sd1);
		set_point_count(7'd4);
		query(16'd0);
		query(16'd1001);
		query(16'd2000);
		query(16'd2999);
		query(16'd3000);
		query(16'd3001);
		query(16'hFFFE);
		query(16'hFFFF);
	endtask

	task automatic test_unordered_abscissas();
		write_point(6'd1, 16'd500, 24'sd1234);
		write_point(6'd2, 16'd200, -24'sd50);
		query(16'd600);
		query(16'd1500);
		query(16'd40000);
	endtask

	task automatic test_random_tables();
		logic [PCOUNT_W-1:0] pc;
		logic [PCOUNT_W-1:0] extremes [5];
		logic signed [YW-1:0] ey;
		logic [XW-1:0] qx;
		int n, cur, step_max, k;
		extremes = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127};
		while (n_items < ITEM_TARGET) begin
			if (n_phases < 5)
				pc = extremes[n_phases];
			else if ($urandom_range(0, 1) != 0)
				pc = PCOUNT_W'($urandom_range(2, 16));
			else
				pc = PCOUNT_W'($urandom_range(0, 127));
			set_point_count(pc);
			n = points_in_use();
			step_max = 131070 / n;
			cur = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 4000);
			// load a nondecreasing table, with the odd stray abscissa
			for (int i = 0; i < n; i++) begin
				if (i > 0 && $urandom_range(0, 7) != 0)
					cur = cur + $urandom_range(0, step_max);
				if (cur > 65535)
					cur = 65535;
				case ($urandom_range(0, 3))
					0:       ey = YW'($urandom_range(0, 2000)) - 24'sd1000;
					1:       ey = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
					default: ey = YW'($urandom);
				endcase
				write_point(IDX_W'(i), ($urandom_range(0, 15) == 0) ? XW'($urandom) : XW'(cur),
					ey);
			end
			repeat ($urandom_range(30, 80)) begin
				if ($urandom_range(0, 4) == 0) begin
					write_point(IDX_W'($urandom), XW'($urandom), YW'($urandom));
				end else begin
					k = $urandom_range(0, n - 1);
					case ($urandom_range(0, 5))
						0: qx = 16'd0;
						1: qx = 16'hFFFF;
						2: qx = knot_x[k];
						3: qx = knot_x[k] - 16'd1;
						4: qx = knot_x[k] + 16'd1;
						default: qx = XW'($urandom);
					endcase
					query(qx);
				end
			end
			n_phases++;
		end
	endtask

	// receiver stall pattern: ready, coin-toss, periodic, then mostly stalled
	always @(posedge clk) begin
		ready_phase <= ready_phase + 1'b1;
		case (ready_phase[11:10])
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= ($urandom_range(0, 1) != 0);
			2'd2: m_axis_tready <= (ready_phase[4:0] > 5'd20);
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_y.size() == 0) begin
				$error("result_y: expected none, actual %0d", $signed(m_axis_tdata[YW-1:0]));
				errors++;
			end else begin
				head_y = expected_y.pop_front();
				if (m_axis_tdata[YW-1:0] !== head_y) begin
					$error("result_y: expected %0d, actual %0d", $signed(head_y),
						$signed(m_axis_tdata[YW-1:0]));
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", idle_cycles);
				$display("tb_piecewise_linear_interpolator failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_one_point();
		test_segments();
		test_unordered_abscissas();
		test_random_tables();
		s_axis_tvalid <= 1'b0;
		while (expected_y.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d items over %0d random tables: %0d queries, %0d breakpoint writes",
			n_items, n_phases, n_queries, n_writes);
		$display("point counts zero, one, full and above full; queries on, beside and past knots");
		if (errors == 0)
			$display("tb_piecewise_linear_interpolator passed");
		else
			$display("tb_piecewise_linear_interpolator failed");
		$finish;
	end

endmodule
